>>> hdl/rcsat_pkg.sv
// rcsat_pkg: shared types, constants and mirror function for the satellite frame decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rcsat_pkg;

  localparam int unsigned NumCh     = 6;
  localparam int unsigned PosW      = 10;
  localparam int unsigned CntW      = 4;
  localparam int unsigned BandW     = 6;

  // Header byte pair: high byte first, then low byte.
  localparam logic [7:0]      HdrHighByte = 8'h03;
  localparam logic [7:0]      HdrLowByte  = 8'h01;

  // Byte counts since the last header where 0x03,0x01 is channel data.
  localparam logic [CntW-1:0] CntDataA    = 4'd8;
  localparam logic [CntW-1:0] CntDataB    = 4'd9;
  localparam logic [CntW-1:0] CntMax      = 4'd10;
  localparam logic [CntW-1:0] CntAfterHdr = 4'd1;

  localparam logic [BandW-1:0] NumBands   = BandW'(NumCh);

  // Default mirror point for reversed channels.
  localparam logic [PosW-1:0] FullScale   = 10'd1023;

  // Configuration register indexes.
  localparam logic RegReverseMask = 1'b0;

  typedef logic [PosW-1:0] pos_t;

  // Decoded state after one byte, handed to the output stage.
  typedef struct packed {
    pos_t [NumCh-1:0] pos;
    logic             frame_start;
    logic             word_done;
  } rcsat_frame_t;

  function automatic pos_t rcsat_mirror(input pos_t pos, input logic rev,
                                        input pos_t full_scale);
    pos_t res;
    res = pos;
    if (rev) begin
      res = (pos > full_scale) ? '0 : pos_t'(full_scale - pos);
    end
    return res;
  endfunction

endpackage

>>> hdl/rcsat_parser.sv
// rcsat_parser: header detection, byte pairing and channel store.
// Depends on rcsat_pkg.
`timescale 1ns / 1ps

module rcsat_parser
  import rcsat_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   rx_byte_i,
  output rcsat_frame_t frame_o
);

  logic [7:0]       last_byte_q, last_byte_d;
  logic             phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  pos_t [NumCh-1:0] store_q, store_d;

  logic             header;
  logic [15:0]      word;
  logic [BandW-1:0] band;
  logic             hit;

  assign word   = {last_byte_q, rx_byte_i};
  assign band   = word[15:PosW];
  assign header = (rx_byte_i == HdrLowByte) && (last_byte_q == HdrHighByte) &&
                  (cnt_q != CntDataA) && (cnt_q != CntDataB);
  // out-of-range words (band 6 and up) are dropped
  assign hit    = !header && phase_q && (band < NumBands);

  always_comb begin
    last_byte_d = rx_byte_i;
    phase_d     = header ? 1'b0 : ~phase_q;
    if (header) begin
      cnt_d = CntAfterHdr;
    end else if (cnt_q < CntMax) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
    for (int i = 0; i < NumCh; i++) begin
      store_d[i] = (hit && (band == BandW'(i))) ? word[PosW-1:0] : store_q[i];
    end
  end

  assign frame_o.pos         = store_d;
  assign frame_o.frame_start = header;
  assign frame_o.word_done   = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_byte_q <= '0;
      phase_q     <= 1'b0;
      cnt_q       <= CntMax;
      store_q     <= '0;
    end else if (accept_i) begin
      last_byte_q <= last_byte_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      store_q     <= store_d;
    end
  end

endmodule

>>> hdl/rcsat_out_stage.sv
// rcsat_out_stage: channel mirroring and the registered result stage.
// Depends on rcsat_pkg.
`timescale 1ns / 1ps

module rcsat_out_stage
  import rcsat_pkg::*;
#(
  parameter pos_t MirrorPoint = FullScale
)
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  rcsat_frame_t frame_i,
  input  logic [NumCh-1:0] reverse_mask_i,
  input  logic         out_stall_i,
  output logic         out_valid_o,
  output logic         busy_o,
  output rcsat_frame_t frame_o
);

  logic         valid_q, valid_d;
  rcsat_frame_t frame_q, frame_d;

  always_comb begin
    frame_d             = frame_i;
    for (int i = 0; i < NumCh; i++) begin
      frame_d.pos[i] = rcsat_mirror(frame_i.pos[i], reverse_mask_i[i], MirrorPoint);
    end
    if (accept_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  // full and held by the sink
  assign busy_o      = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign frame_o     = frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      frame_q <= frame_d;
    end
  end

endmodule

>>> hdl/rc_satellite_frame_decoder.sv
// rc_satellite_frame_decoder: top level, APB register and channel wiring.
// Depends on rcsat_pkg, rcsat_parser and rcsat_out_stage.
`timescale 1ns / 1ps

// Decoder for the byte stream of a DSM2-style satellite receiver. Each item
// on the rx channel is one received byte; each byte yields exactly one
// result item holding all six channel positions (throttle, aileron,
// elevator, rudder, gear, flap) as they stand after that byte, plus
// frame_start (the byte completed a 0x03,0x01 header) and word_done (the
// byte completed a word that was stored). A header pair arriving at byte
// count 8 or 9 since the last header is taken as channel data. After a
// header, bytes pair up high-then-low into a 16-bit word; bits 12..10 pick
// the channel, bits 9..0 are the position, and words of 6144 and up are
// dropped. Channels whose bit is set in reverse_mask (APB offset 0x0,
// bit 0 throttle .. bit 5 flap) read as MirrorPoint (default 1023) minus
// their position, or 0 when the position lies above MirrorPoint.
// Throughput is one byte per clock while rx_stall_o is low: the decode is a
// few compares and a store update ahead of a single result register, and
// the result appears in the cycle after the byte is accepted. rx_stall_o
// rises only while a result sits in that register and out_stall_i holds it.
// Change reverse_mask only while no result is pending.
module rc_satellite_frame_decoder
  import rcsat_pkg::*;
#(
  parameter pos_t MirrorPoint = FullScale
)
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  throttle_pos_o,
  output logic [9:0]  aileron_pos_o,
  output logic [9:0]  elevator_pos_o,
  output logic [9:0]  rudder_pos_o,
  output logic [9:0]  gear_pos_o,
  output logic [9:0]  flap_pos_o,
  output logic        frame_start_o,
  output logic        word_done_o,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             accept;
  logic             busy;
  logic [NumCh-1:0] reverse_mask_q;
  rcsat_frame_t     dec_frame;
  rcsat_frame_t     res_frame;

  // APB: single register, zero wait states
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegReverseMask) ? 32'(reverse_mask_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_mask_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == RegReverseMask)) begin
      reverse_mask_q <= pwdata[NumCh-1:0];
    end
  end

  // Byte accepted whenever the result register can take the new item.
  assign rx_stall_o = busy;
  assign accept     = rx_valid_i && !busy;

  rcsat_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .frame_o   (dec_frame)
  );

  rcsat_out_stage #(
    .MirrorPoint (MirrorPoint)
  ) u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .frame_i        (dec_frame),
    .reverse_mask_i (reverse_mask_q),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .busy_o         (busy),
    .frame_o        (res_frame)
  );

  assign throttle_pos_o = res_frame.pos[0];
  assign aileron_pos_o  = res_frame.pos[1];
  assign elevator_pos_o = res_frame.pos[2];
  assign rudder_pos_o   = res_frame.pos[3];
  assign gear_pos_o     = res_frame.pos[4];
  assign flap_pos_o     = res_frame.pos[5];
  assign frame_start_o  = res_frame.frame_start;
  assign word_done_o    = res_frame.word_done;

endmodule

>>> tb/rc_satellite_frame_decoder_tb.sv
// rc_satellite_frame_decoder_tb: self-checking testbench for the satellite frame decoder.
// Depends on rcsat_pkg and the rc_satellite_frame_decoder RTL; nothing else.
// Directed header, data and edge-case bytes first, then randomized frames and noise.
`timescale 1ns / 1ps

module rc_satellite_frame_decoder_tb
  import rcsat_pkg::*;
;

  // Tracks the decoder's byte parser and channel store, and queues the
  // result expected for every accepted byte.
  class channel_tracker;
    logic [7:0]      prev_byte;
    bit              odd_phase;
    logic [CntW-1:0] since_hdr;
    pos_t            store [NumCh];
    logic [NumCh-1:0] rev_mask;
    rcsat_frame_t    expected_frames [$];
    string           ch_names [NumCh];
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     headers;
    int unsigned     words;

    function new();
      prev_byte  = '0;
      odd_phase  = 1'b0;
      since_hdr  = CntMax;
      rev_mask   = '0;
      mismatches = 0;
      checked    = 0;
      headers    = 0;
      words      = 0;
      foreach (store[i]) store[i] = '0;
      ch_names = '{"throttle", "aileron", "elevator", "rudder", "gear", "flap"};
    endfunction

    // Only index 0 exists; bits above the mask are dropped.
    function void write_reg(int unsigned index, logic [31:0] value);
      if (index == 0) rev_mask = value[NumCh-1:0];
    endfunction

    function void take_byte(logic [7:0] b);
      rcsat_frame_t f;
      logic [15:0]  word;
      logic         hdr;
      logic         done;
      hdr  = 1'b0;
      done = 1'b0;
      // 0x03,0x01 at count 8 or 9 is channel data, not a header
      if (b == HdrLowByte && prev_byte == HdrHighByte &&
          since_hdr != CntDataA && since_hdr != CntDataB) begin
        hdr       = 1'b1;
        odd_phase = 1'b1;
        since_hdr = '0;
      end else if (odd_phase) begin
        word = {prev_byte, b};
        if (word[15:10] < NumBands) begin
          store[word[12:10]] = word[9:0];
          done = 1'b1;
        end
      end
      if (since_hdr < CntMax) since_hdr = since_hdr + 1'b1;
      prev_byte = b;
      odd_phase = !odd_phase;
      for (int i = 0; i < NumCh; i++) begin
        if (!rev_mask[i]) f.pos[i] = store[i];
        else if (store[i] > FullScale) f.pos[i] = '0;
        else f.pos[i] = FullScale - store[i];
      end
      f.frame_start = hdr;
      f.word_done   = done;
      headers += hdr;
      words   += done;
      expected_frames.push_back(f);
    endfunction

    function void check_frame(rcsat_frame_t act);
      rcsat_frame_t exp_f;
      if (expected_frames.size() == 0) begin
        $display("%0t: result with nothing expected (throttle %0d, start %0b, done %0b)",
                 $time, act.pos[0], act.frame_start, act.word_done);
        mismatches++;
        return;
      end
      exp_f = expected_frames.pop_front();
      checked++;
      for (int i = 0; i < NumCh; i++) begin
        if (act.pos[i] !== exp_f.pos[i]) begin
          $display("%0t: %s_pos expected %0d, actual %0d",
                   $time, ch_names[i], exp_f.pos[i], act.pos[i]);
          mismatches++;
        end
      end
      if (act.frame_start !== exp_f.frame_start) begin
        $display("%0t: frame_start expected %0b, actual %0b",
                 $time, exp_f.frame_start, act.frame_start);
        mismatches++;
      end
      if (act.word_done !== exp_f.word_done) begin
        $display("%0t: word_done expected %0b, actual %0b",
                 $time, exp_f.word_done, act.word_done);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction
  endclass

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned PhaseItems = 150;
  localparam logic [2:0]  AddrReverseMask = 3'd0;
  localparam logic [2:0]  AddrUnused      = 3'd4;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        rx_valid_i  = 1'b0;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [9:0]  throttle_pos_o;
  logic [9:0]  aileron_pos_o;
  logic [9:0]  elevator_pos_o;
  logic [9:0]  rudder_pos_o;
  logic [9:0]  gear_pos_o;
  logic [9:0]  flap_pos_o;
  logic        frame_start_o;
  logic        word_done_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // Pacing knobs, set by the main sequence per phase.
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned items_sent   = 0;
  int unsigned cycle_count  = 0;

  channel_tracker tracker = new();

  rc_satellite_frame_decoder i_dut (
    .clk_i,
    .rst_ni,
    .rx_valid_i,
    .rx_stall_o,
    .rx_byte_i,
    .out_valid_o,
    .out_stall_i,
    .throttle_pos_o,
    .aileron_pos_o,
    .elevator_pos_o,
    .rudder_pos_o,
    .gear_pos_o,
    .flap_pos_o,
    .frame_start_o,
    .word_done_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, tracker.pending());
      $display("rc_satellite_frame_decoder: mismatch");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request that is
  // counted here so the sender keeps pushing and the decoder backs up.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LongHold;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    rcsat_frame_t act;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      act.pos[0]      = throttle_pos_o;
      act.pos[1]      = aileron_pos_o;
      act.pos[2]      = elevator_pos_o;
      act.pos[3]      = rudder_pos_o;
      act.pos[4]      = gear_pos_o;
      act.pos[5]      = flap_pos_o;
      act.frame_start = frame_start_o;
      act.word_done   = word_done_o;
      tracker.check_frame(act);
    end
  end

  // Offer one byte after a random gap, hold it until accepted.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      rx_valid_i = 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (rx_stall_o);
    tracker.take_byte(b);
    items_sent++;
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  // Channel word: mostly valid bands, sometimes out of range or the
  // header pattern itself as data.
  task automatic send_channel_word();
    int unsigned pick;
    logic [15:0] w;
    pick = $urandom_range(99);
    if (pick < 6) begin
      w = {HdrHighByte, HdrLowByte};
    end else if (pick < 14) begin
      w = 16'($urandom_range(65535, 6144));
    end else begin
      w = {3'b000, 3'($urandom_range(NumCh - 1)), 10'($urandom_range(1023))};
    end
    send_word(w);
  endtask

  task automatic send_random_phase(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // well-formed frame, usually the full seven words
        send_word({HdrHighByte, HdrLowByte});
        n = ($urandom_range(3) == 0) ? $urandom_range(7, 1) : 7;
        repeat (n) send_channel_word();
      end else if (pick < 85) begin
        // noise, rich in header bytes so headers land at odd offsets
        n = $urandom_range(5, 1);
        repeat (n) begin
          case ($urandom_range(2))
            0: send_byte(HdrHighByte);
            1: send_byte(HdrLowByte);
            default: send_byte(8'($urandom_range(255)));
          endcase
        end
      end else begin
        // truncated frame, often cut mid-word
        send_word({HdrHighByte, HdrLowByte});
        n = $urandom_range(6, 1);
        repeat (n) send_byte(8'($urandom_range(255)));
      end
    end
    @(negedge clk_i);
    rx_valid_i = 1'b0;
  endtask

  // Register write once the decoder has drained.
  task automatic write_reg_idle(input logic [2:0] addr, input logic [31:0] data);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.write_reg(addr >> 2, data);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  initial begin
    // Header at reset, zero word to throttle, each band, the header pair
    // as data at counts 8 and 9, band 5 top word, first out-of-range word,
    // and a header after the counter has saturated.
    logic [7:0] directed_bytes [26] = '{
      8'h03, 8'h01, 8'h00, 8'h00, 8'h07, 8'hFF, 8'h09, 8'h55, 8'h03, 8'h01,
      8'h0C, 8'h2A, 8'h03, 8'h01, 8'h13, 8'hFF, 8'h17, 8'hFF, 8'h18, 8'h00,
      8'hFF, 8'h03, 8'h01, 8'hFF, 8'h03, 8'h01
    };
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    @(negedge clk_i);
    rx_valid_i = 1'b0;

    // All channels mirrored, no idling on either side.
    write_reg_idle(AddrReverseMask, 32'h0000_003F);
    send_random_phase(PhaseItems);

    // Write to the unused slot must not touch the mask; upper bits dropped.
    write_reg_idle(AddrUnused, 32'h0000_0000);
    write_reg_idle(AddrReverseMask, 32'hFFFF_FFEA);
    tx_idle_pct = 58;
    send_random_phase(PhaseItems);

    // No mirroring, receiver stalls, one long hold-off to back up the input.
    write_reg_idle(AddrReverseMask, 32'h0000_0000);
    tx_idle_pct  = 0;
    rx_stall_pct = 58;
    hold_request = 1'b1;
    send_random_phase(PhaseItems);

    // Random mask, both sides idling.
    write_reg_idle(AddrReverseMask, $urandom);
    tx_idle_pct  = 34;
    rx_stall_pct = 34;
    send_random_phase(PhaseItems);

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("checked %0d results from %0d bytes: %0d headers, %0d stored words,",
             tracker.checked, items_sent, tracker.headers, tracker.words);
    $display("over four pacing phases and five reverse mask settings");
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("rc_satellite_frame_decoder: match");
    end else begin
      $display("rc_satellite_frame_decoder: mismatch");
    end
    $finish;
  end

endmodule
